// File: rtl/adb_mouse_device_responder_assert.svh
// ----------------------------------------------------------------------------
// adb mouse device responder assertion macros
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ADB_MOUSE_DEVICE_RESPONDER_ASSERT_SVH
`define ADB_MOUSE_DEVICE_RESPONDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ADBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ADBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ADBM_ASSERT_NOW(label, clk, rst, ante, cons, msg)

`define ADBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/adbm_pkg.sv
// ----------------------------------------------------------------------------
// adb mouse package
// shared types, command codes and reset defaults of the mouse responder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adbm_pkg;

   localparam logic [3:0] DEFAULT_ADDRESS = 4'd3;
   localparam logic [7:0] DEFAULT_HANDLER = 8'd2;

   localparam logic [1:0] REG_MOTION = 2'd0;
   localparam logic [1:0] REG_ID     = 2'd3;

   localparam logic [7:0] LISTEN_KEEP  = 8'hFE;
   localparam logic [7:0] ID_HIGH_BITS = 8'h60;

   localparam logic signed [15:0] REPORT_MAX = 16'sd63;
   localparam logic signed [15:0] REPORT_MIN = -16'sd64;
   localparam logic signed [15:0] SUM_MAX    = 16'sh7FFF;
   localparam logic signed [15:0] SUM_MIN    = 16'sh8000;

   typedef enum logic [2:0] {
      CMD_MOVE   = 3'd0,
      CMD_TALK   = 3'd1,
      CMD_LISTEN = 3'd2,
      CMD_FLUSH  = 3'd3,
      CMD_RESET  = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [1:0]         reg_sel;
      logic [15:0]        listen_word;
      logic signed [7:0]  move_dx;
      logic signed [7:0]  move_dy;
      logic               button_down;
   } item_type;

   typedef struct packed {
      logic [3:0]         dev_address;
      logic [7:0]         dev_handler;
      logic signed [15:0] sum_dx;
      logic signed [15:0] sum_dy;
      logic               pressed;
      logic               press_changed;
   } state_type;

   typedef struct packed {
      logic        reply_valid;
      logic [15:0] reply_word;
   } reply_type;

   localparam state_type STATE_DEFAULT = '{
      dev_address:   DEFAULT_ADDRESS,
      dev_handler:   DEFAULT_HANDLER,
      sum_dx:        16'sd0,
      sum_dy:        16'sd0,
      pressed:       1'b0,
      press_changed: 1'b0
   };

endpackage

// File: rtl/adb_mouse_device_responder.sv
// ----------------------------------------------------------------------------
// adb mouse device responder
// device side of a desktop-bus mouse: motion accumulation and talk replies
// ----------------------------------------------------------------------------
// req channel carries one command or move event per transaction; every talk
// produces exactly one rsp transaction (reply_valid 0 means no answer),
// all other commands produce none
// a transaction is captured in an input register and executed against the
// device state when it leaves that register, its reply landing in the output
// register, from which it is presented on rsp
// throughput is one transaction per cycle while req_stall is low, set by the
// state update between the input register and the state registers
// while a reply waits under rsp_stall, non-talk transactions keep flowing;
// a talk waiting behind it holds in the input register and req_stall rises
// synchronous reset empties both registers and loads the default address,
// handler and zero motion; req_stall is low out of reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "adb_mouse_device_responder_assert.svh"

module adb_mouse_device_responder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_cmd,
   input  logic [1:0]        req_reg_sel,
   input  logic [15:0]       req_listen_word,
   input  logic signed [7:0] req_move_dx,
   input  logic signed [7:0] req_move_dy,
   input  logic              req_button_down,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_reply_valid,
   output logic [15:0]       rsp_reply_word
);

   logic                in_vld_ff;
   logic                in_vld_in;
   adbm_pkg::item_type  in_item_ff;
   adbm_pkg::item_type  in_item_in;
   adbm_pkg::item_type  req_item;
   adbm_pkg::state_type state_ff;
   adbm_pkg::state_type state_in;
   adbm_pkg::state_type core_state;
   adbm_pkg::reply_type core_reply;
   logic                out_vld_ff;
   logic                out_vld_in;
   adbm_pkg::reply_type out_reply_ff;
   adbm_pkg::reply_type out_reply_in;
   logic                accept;
   logic                in_talk;
   logic                advance;
   logic                fire;

   assign req_item = '{
      cmd:         adbm_pkg::cmd_type'(req_cmd),
      reg_sel:     req_reg_sel,
      listen_word: req_listen_word,
      move_dx:     req_move_dx,
      move_dy:     req_move_dy,
      button_down: req_button_down
   };

   adbm_core u_core (
      .item      (in_item_ff),
      .cur_state (state_ff),
      .nxt_state (core_state),
      .reply     (core_reply)
   );

   // handshake and flow control
   assign in_talk   = (in_item_ff.cmd == adbm_pkg::CMD_TALK);
   assign advance   = !in_talk || !out_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && advance;
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_vld_in  = accept || (in_vld_ff && !fire);
   assign in_item_in = accept ? req_item : in_item_ff;
   assign state_in   = fire ? core_state : state_ff;

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_reply_in = out_reply_ff;
      if (fire && in_talk) begin
         out_vld_in   = 1'b1;
         out_reply_in = core_reply;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= adbm_pkg::STATE_DEFAULT;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         state_ff   <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff   <= in_item_in;
      out_reply_ff <= out_reply_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_reply_valid = out_reply_ff.reply_valid;
   assign rsp_reply_word  = out_reply_ff.reply_word;

   // assertions
   `ADBM_ASSERT_NOW(a_no_reply_zero, clock, reset,
      rsp_valid && !rsp_reply_valid, rsp_reply_word == 16'd0,
      "reply word not zero without reply")
   `ADBM_ASSERT_NOW(a_talk_held, clock, reset,
      in_vld_ff && in_talk && rsp_valid && rsp_stall, req_stall,
      "talk transaction taken over a stalled reply")
   `ADBM_ASSERT_NEXT(a_reset_cmd, clock, reset,
      fire && in_item_ff.cmd == adbm_pkg::CMD_RESET,
      state_ff == adbm_pkg::STATE_DEFAULT,
      "reset command did not restore defaults")
   `ADBM_ASSERT_NEXT(a_listen_keeps_motion, clock, reset,
      fire && in_item_ff.cmd == adbm_pkg::CMD_LISTEN,
      $stable(state_ff.sum_dx) && $stable(state_ff.sum_dy)
         && $stable(state_ff.press_changed),
      "listen changed motion state")

endmodule

// File: rtl/adbm_core.sv
// ----------------------------------------------------------------------------
// adb mouse command core
// next device state and talk reply for one command or move event
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adbm_core (
   input  adbm_pkg::item_type  item,
   input  adbm_pkg::state_type cur_state,
   output adbm_pkg::state_type nxt_state,
   output adbm_pkg::reply_type reply
);

   logic [16:0]        wide_dx;
   logic [16:0]        wide_dy;
   logic signed [15:0] sat_dx;
   logic signed [15:0] sat_dy;
   logic signed [15:0] rep_dx;
   logic signed [15:0] rep_dy;
   logic               has_motion;
   logic [7:0]         lsn_addr;
   logic [7:0]         lsn_handler;

   // saturating accumulate
   always_comb begin
      wide_dx = {cur_state.sum_dx[15], cur_state.sum_dx}
              + {{9{item.move_dx[7]}}, item.move_dx};
      wide_dy = {cur_state.sum_dy[15], cur_state.sum_dy}
              + {{9{item.move_dy[7]}}, item.move_dy};
      if (wide_dx[16] != wide_dx[15]) begin
         sat_dx = wide_dx[16] ? adbm_pkg::SUM_MIN : adbm_pkg::SUM_MAX;
      end else begin
         sat_dx = wide_dx[15:0];
      end
      if (wide_dy[16] != wide_dy[15]) begin
         sat_dy = wide_dy[16] ? adbm_pkg::SUM_MIN : adbm_pkg::SUM_MAX;
      end else begin
         sat_dy = wide_dy[15:0];
      end
   end

   // report clamp
   always_comb begin
      priority if (cur_state.sum_dx > adbm_pkg::REPORT_MAX) begin
         rep_dx = adbm_pkg::REPORT_MAX;
      end else if (cur_state.sum_dx < adbm_pkg::REPORT_MIN) begin
         rep_dx = adbm_pkg::REPORT_MIN;
      end else begin
         rep_dx = cur_state.sum_dx;
      end
      priority if (cur_state.sum_dy > adbm_pkg::REPORT_MAX) begin
         rep_dy = adbm_pkg::REPORT_MAX;
      end else if (cur_state.sum_dy < adbm_pkg::REPORT_MIN) begin
         rep_dy = adbm_pkg::REPORT_MIN;
      end else begin
         rep_dy = cur_state.sum_dy;
      end
   end

   assign has_motion  = (cur_state.sum_dx != 16'sd0) || (cur_state.sum_dy != 16'sd0)
                      || cur_state.press_changed;
   assign lsn_addr    = item.listen_word[15:8];
   assign lsn_handler = item.listen_word[7:0];

   always_comb begin
      nxt_state = cur_state;
      reply     = '0;
      unique case (item.cmd)
         adbm_pkg::CMD_MOVE: begin
            nxt_state.sum_dx = sat_dx;
            nxt_state.sum_dy = sat_dy;
            if (item.button_down != cur_state.pressed) begin
               nxt_state.pressed       = item.button_down;
               nxt_state.press_changed = 1'b1;
            end
         end
         adbm_pkg::CMD_TALK: begin
            if (item.reg_sel == adbm_pkg::REG_MOTION) begin
               if (has_motion) begin
                  nxt_state.sum_dx        = cur_state.sum_dx - rep_dx;
                  nxt_state.sum_dy        = cur_state.sum_dy - rep_dy;
                  nxt_state.press_changed = 1'b0;
                  reply.reply_valid       = 1'b1;
                  reply.reply_word        = {~cur_state.pressed, rep_dy[6:0],
                                             1'b1, rep_dx[6:0]};
               end
            end else if (item.reg_sel == adbm_pkg::REG_ID) begin
               reply.reply_valid = 1'b1;
               reply.reply_word  = {adbm_pkg::ID_HIGH_BITS | {4'd0, cur_state.dev_address},
                                    cur_state.dev_handler};
            end
         end
         adbm_pkg::CMD_LISTEN: begin
            if (item.reg_sel == adbm_pkg::REG_ID) begin
               if (lsn_addr != 8'd0 && lsn_addr != adbm_pkg::LISTEN_KEEP) begin
                  nxt_state.dev_address = lsn_addr[3:0];
               end
               if (lsn_handler != 8'd0 && lsn_handler != adbm_pkg::LISTEN_KEEP) begin
                  nxt_state.dev_handler = lsn_handler;
               end
            end
         end
         adbm_pkg::CMD_FLUSH: begin
            nxt_state.sum_dx        = 16'sd0;
            nxt_state.sum_dy        = 16'sd0;
            nxt_state.press_changed = 1'b0;
         end
         adbm_pkg::CMD_RESET: begin
            nxt_state = adbm_pkg::STATE_DEFAULT;
         end
         default: begin
            nxt_state = cur_state;
         end
      endcase
   end

endmodule

// File: bench/tb_adb_mouse_device_responder.sv
// ----------------------------------------------------------------------------
// adb mouse device responder testbench
// drives move, talk, listen, flush, reset and spare-code transactions with random gaps
// and back-pressure, predicts every talk reply from a model of the device
// state and compares each reply field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adb_mouse_device_responder;

   localparam logic [1:0] REG_SPARE_LO = 2'd1;
   localparam logic [1:0] REG_SPARE_HI = 2'd2;
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int TOTAL_ITEMS = 1880;
   localparam int HOLD_CYCLES = 150;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SAT_RUN     = 280;

   class talk_reply_ledger;
      logic [3:0]          address;
      logic [7:0]          handler;
      int                  sum_x;
      int                  sum_y;
      bit                  pressed;
      bit                  changed;
      adbm_pkg::reply_type due[$];
      int                  errors;
      int                  answered;
      int                  silent;
      int                  saturations;

      function new();
         errors = 0;
         answered = 0;
         silent = 0;
         saturations = 0;
         restore();
      endfunction

      function void restore();
         address = adbm_pkg::DEFAULT_ADDRESS;
         handler = adbm_pkg::DEFAULT_HANDLER;
         sum_x = 0;
         sum_y = 0;
         pressed = 1'b0;
         changed = 1'b0;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function int saturate(int v);
         if (v > int'(adbm_pkg::SUM_MAX)) begin
            saturations++;
            return int'(adbm_pkg::SUM_MAX);
         end
         if (v < int'(adbm_pkg::SUM_MIN)) begin
            saturations++;
            return int'(adbm_pkg::SUM_MIN);
         end
         return v;
      endfunction

      function int clip(int v);
         if (v > int'(adbm_pkg::REPORT_MAX)) return int'(adbm_pkg::REPORT_MAX);
         if (v < int'(adbm_pkg::REPORT_MIN)) return int'(adbm_pkg::REPORT_MIN);
         return v;
      endfunction

      function void note_request(adbm_pkg::item_type it);
         adbm_pkg::reply_type r;
         int                  rx;
         int                  ry;
         r = '0;
         case (it.cmd)
            adbm_pkg::CMD_MOVE: begin
               sum_x = saturate(sum_x + int'($signed(it.move_dx)));
               sum_y = saturate(sum_y + int'($signed(it.move_dy)));
               if (it.button_down != pressed) begin
                  pressed = it.button_down;
                  changed = 1'b1;
               end
            end
            adbm_pkg::CMD_TALK: begin
               if (it.reg_sel == adbm_pkg::REG_MOTION) begin
                  if (sum_x != 0 || sum_y != 0 || changed) begin
                     rx = clip(sum_x);
                     ry = clip(sum_y);
                     sum_x -= rx;
                     sum_y -= ry;
                     changed = 1'b0;
                     r.reply_valid = 1'b1;
                     r.reply_word = {~pressed, 7'(ry), 1'b1, 7'(rx)};
                  end
               end else if (it.reg_sel == adbm_pkg::REG_ID) begin
                  r.reply_valid = 1'b1;
                  r.reply_word = {adbm_pkg::ID_HIGH_BITS | {4'h0, address}, handler};
               end
               due.push_back(r);
            end
            adbm_pkg::CMD_LISTEN: begin
               if (it.reg_sel == adbm_pkg::REG_ID) begin
                  if (it.listen_word[15:8] != 8'h00
                      && it.listen_word[15:8] != adbm_pkg::LISTEN_KEEP)
                     address = it.listen_word[11:8];
                  if (it.listen_word[7:0] != 8'h00
                      && it.listen_word[7:0] != adbm_pkg::LISTEN_KEEP)
                     handler = it.listen_word[7:0];
               end
            end
            adbm_pkg::CMD_FLUSH: begin
               sum_x = 0;
               sum_y = 0;
               changed = 1'b0;
            end
            adbm_pkg::CMD_RESET: restore();
            default: ;
         endcase
      endfunction

      function void check_reply(logic rv, logic [15:0] rw);
         adbm_pkg::reply_type e;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: reply with nothing pending, valid %0b word %h", $time, rv, rw);
            return;
         end
         e = due.pop_front();
         if (rv !== e.reply_valid) begin
            errors++;
            $display("%0t: reply_valid expected %0b actual %0b", $time, e.reply_valid, rv);
         end
         if (rw !== e.reply_word) begin
            errors++;
            $display("%0t: reply_word expected %h actual %h", $time, e.reply_word, rw);
         end
         if (e.reply_valid) answered++;
         else silent++;
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_cmd = '0;
   logic [1:0]        req_reg_sel = '0;
   logic [15:0]       req_listen_word = '0;
   logic signed [7:0] req_move_dx = '0;
   logic signed [7:0] req_move_dy = '0;
   logic              req_button_down = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_reply_valid;
   logic [15:0]       rsp_reply_word;

   bit hold_replies = 1'b0;
   bit sender_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int sent_items = 0;

   talk_reply_ledger book = new();

   adb_mouse_device_responder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_reg_sel     (req_reg_sel),
      .req_listen_word (req_listen_word),
      .req_move_dx     (req_move_dx),
      .req_move_dy     (req_move_dy),
      .req_button_down (req_button_down),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reply_valid (rsp_reply_valid),
      .rsp_reply_word  (rsp_reply_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic adbm_pkg::item_type noise_item();
      adbm_pkg::item_type it;
      it.cmd = adbm_pkg::cmd_type'(3'($urandom_range(0, CMD_SPARE_HI)));
      it.reg_sel = 2'($urandom);
      it.listen_word = 16'($urandom);
      it.move_dx = 8'($urandom);
      it.move_dy = 8'($urandom);
      it.button_down = 1'($urandom);
      return it;
   endfunction

   function automatic logic [7:0] id_byte();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return adbm_pkg::LISTEN_KEEP;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_delta();
      if ($urandom_range(0, 3) != 0) return 8'($urandom);
      case ($urandom_range(0, 4))
         0: return 8'sh7F;
         1: return 8'sh80;
         2: return 8'sh00;
         3: return 8'sh01;
         default: return 8'shFF;
      endcase
   endfunction

   // one transaction on req, entered and left at a falling edge
   task automatic send_request(input adbm_pkg::item_type it);
      int gap;
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd = it.cmd;
      req_reg_sel = it.reg_sel;
      req_listen_word = it.listen_word;
      req_move_dx = it.move_dx;
      req_move_dy = it.move_dy;
      req_button_down = it.button_down;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(it);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_move(input logic [7:0] dx, input logic [7:0] dy, input logic btn);
      adbm_pkg::item_type it;
      it = noise_item();
      it.cmd = adbm_pkg::CMD_MOVE;
      it.move_dx = dx;
      it.move_dy = dy;
      it.button_down = btn;
      send_request(it);
   endtask

   task automatic send_talk(input logic [1:0] sel);
      adbm_pkg::item_type it;
      it = noise_item();
      it.cmd = adbm_pkg::CMD_TALK;
      it.reg_sel = sel;
      send_request(it);
   endtask

   task automatic send_listen(input logic [1:0] sel, input logic [15:0] word);
      adbm_pkg::item_type it;
      it = noise_item();
      it.cmd = adbm_pkg::CMD_LISTEN;
      it.reg_sel = sel;
      it.listen_word = word;
      send_request(it);
   endtask

   task automatic send_plain(input logic [2:0] code);
      adbm_pkg::item_type it;
      it = noise_item();
      it.cmd = adbm_pkg::cmd_type'(code);
      send_request(it);
   endtask

   task automatic drain_replies();
      req_valid = 1'b0;
      while (book.pending() != 0) @(negedge clock);
   endtask

   // reply side back-pressure
   initial begin
      int n;
      forever begin
         if (hold_replies) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_replies = 1'b0;
         end else begin
            n = rsp_quiet ? 0 : pick_gap();
            if (n > 0) begin
               rsp_stall = 1'b1;
               repeat (n) @(negedge clock);
            end
         end
         rsp_stall = 1'b0;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_reply(rsp_reply_valid, rsp_reply_word);
   end

   // watchdog on cycles without any transaction
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int         seq;
      int         kind;
      int         n;
      int         c;
      logic       btn;
      logic [7:0] sat_x;
      logic [7:0] sat_y;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty motion talk, id, spare registers, clamping, button change
      send_talk(adbm_pkg::REG_MOTION);
      send_talk(adbm_pkg::REG_ID);
      send_talk(REG_SPARE_LO);
      send_talk(REG_SPARE_HI);
      send_move(8'sh7F, 8'sh80, 1'b1);
      repeat (3) send_talk(adbm_pkg::REG_MOTION);
      send_move(8'sh00, 8'sh00, 1'b1);
      send_talk(adbm_pkg::REG_MOTION);
      send_move(8'sh00, 8'sh00, 1'b0);
      send_talk(adbm_pkg::REG_MOTION);
      // listen keep codes, zero nibble address, ignored registers
      send_listen(adbm_pkg::REG_ID, 16'h0000);
      send_listen(adbm_pkg::REG_ID, {adbm_pkg::LISTEN_KEEP, adbm_pkg::LISTEN_KEEP});
      send_talk(adbm_pkg::REG_ID);
      send_listen(adbm_pkg::REG_ID, 16'h1080);
      send_listen(adbm_pkg::REG_MOTION, 16'hFFFF);
      send_talk(adbm_pkg::REG_ID);
      send_listen(adbm_pkg::REG_ID, 16'hFFFF);
      send_talk(adbm_pkg::REG_ID);
      // flush keeps button, then spare commands and reset
      send_move(8'sh80, 8'sh7F, 1'b1);
      send_plain(adbm_pkg::CMD_FLUSH);
      send_talk(adbm_pkg::REG_MOTION);
      for (c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) send_plain(3'(c));
      send_plain(adbm_pkg::CMD_RESET);
      send_talk(adbm_pkg::REG_ID);

      seq = 0;
      btn = 1'b0;
      while (sent_items < TOTAL_ITEMS) begin
         sender_quiet = ($urandom_range(0, 4) == 0);
         rsp_quiet = ($urandom_range(0, 4) == 0);
         if (seq == 10 || seq == 140) begin
            hold_replies = 1'b1;
            sender_quiet = 1'b1;
            repeat (40)
               send_talk($urandom_range(0, 1) ? adbm_pkg::REG_MOTION : adbm_pkg::REG_ID);
            drain_replies();
         end else if (seq == 40 || seq == 90) begin
            sat_x = (seq == 40) ? 8'sh7F : 8'sh80;
            sat_y = (seq == 40) ? 8'sh80 : 8'sh7F;
            send_plain(adbm_pkg::CMD_FLUSH);
            for (n = 0; n < SAT_RUN; n++) send_move(sat_x, sat_y, btn);
            repeat (4) send_talk(adbm_pkg::REG_MOTION);
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               n = $urandom_range(1, 8);
               repeat (n) begin
                  if ($urandom_range(0, 4) == 0) btn = ~btn;
                  send_move(pick_delta(), pick_delta(), btn);
               end
               repeat ($urandom_range(1, 3)) send_talk(adbm_pkg::REG_MOTION);
            end else if (kind < 58) begin
               send_talk(adbm_pkg::REG_MOTION);
            end else if (kind < 70) begin
               send_listen(adbm_pkg::REG_ID, {id_byte(), id_byte()});
               send_talk(adbm_pkg::REG_ID);
            end else if (kind < 77) begin
               send_listen(2'($urandom), 16'($urandom));
            end else if (kind < 83) begin
               send_plain(adbm_pkg::CMD_FLUSH);
            end else if (kind < 86) begin
               send_plain(adbm_pkg::CMD_RESET);
               btn = 1'b0;
            end else if (kind < 93) begin
               send_talk(2'($urandom));
            end else if (kind < 98) begin
               send_request(noise_item());
            end else begin
               drain_replies();
            end
         end
         seq++;
      end

      drain_replies();
      repeat (8) @(posedge clock);
      $display("ran %0d transactions: %0d talk replies answered, %0d without answer",
               sent_items, book.answered, book.silent);
      $display("accumulator saturated %0d times, %0d mismatches",
               book.saturations, book.errors);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
